>>> rtl/core/extreme_run_center_select_macros.svh
// assertion macros for the extreme run center select block
// used by rtl/core files that carry concurrent checks; no other dependencies
`ifndef EXTREME_RUN_CENTER_SELECT_MACROS_SVH
`define EXTREME_RUN_CENTER_SELECT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while in reset
`define ERC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("erc check failed");

// next-cycle implication, disabled while in reset
`define ERC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("erc check failed");

`else

`define ERC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ERC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/erc_pkg.sv
// shared constants and types for the extreme run center select block
// no dependencies
`default_nettype none

package erc_pkg;

    localparam int MAX_ITEMS_DEF = 256;
    localparam int DIST_BITS_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int CENTER_W = 8;

    typedef struct packed {
        logic [CENTER_W-1:0] center_index;
        logic [SAMPLE_W-1:0] extreme_distance;
        logic                overflow;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/erc_in_if.sv
// sample channel: valid/ready handshake with distance and last marker
// depends on erc_pkg
`default_nettype none

interface erc_in_if;

    logic                          valid;
    logic                          ready;
    logic [erc_pkg::SAMPLE_W-1:0]  distance_sample;
    logic                          last_sample;

    modport source (output valid, output distance_sample, output last_sample, input ready);
    modport sink (input valid, input distance_sample, input last_sample, output ready);

endinterface

`default_nettype wire

>>> rtl/core/erc_out_if.sv
// result channel: valid/ready handshake with center, extreme and overflow
// depends on erc_pkg
`default_nettype none

interface erc_out_if;

    logic                          valid;
    logic                          ready;
    logic [erc_pkg::CENTER_W-1:0]  center_index;
    logic [erc_pkg::SAMPLE_W-1:0]  extreme_distance;
    logic                          overflow;

    modport source (output valid, output center_index, output extreme_distance,
                    output overflow, input ready);
    modport sink (input valid, input center_index, input extreme_distance,
                  input overflow, output ready);

endinterface

`default_nettype wire

>>> rtl/core/extreme_run_center_select.sv
// output: a result is loaded into the output register and appears in the cycle after its last sample
// throughput: one sample per cycle; the tracker folds each sample into its state
//   in a single pass, and samples stall only while a result waits unaccepted
// reset: sequence state clears, no result pending, mode register selects minimum
// depends on erc_pkg, erc_in_if, erc_out_if, erc_run_tracker, erc_result_reg
`default_nettype none

module extreme_run_center_select #(
    parameter int MAX_ITEMS = erc_pkg::MAX_ITEMS_DEF,
    parameter int DIST_BITS = erc_pkg::DIST_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_wr_en,
    input  wire logic cfg_wr_data,
    erc_in_if.sink    samples,
    erc_out_if.source results
);

    logic             find_minimum_reg;
    logic             can_take;
    logic             take;
    logic             res_load;
    erc_pkg::result_t res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            find_minimum_reg <= 1'b1;
        else if (cfg_wr_en)
            find_minimum_reg <= cfg_wr_data;
    end

    assign samples.ready = can_take;
    assign take          = samples.valid && can_take;

    erc_run_tracker #(
        .MAX_ITEMS (MAX_ITEMS),
        .DIST_BITS (DIST_BITS)
    ) u_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .distance_sample (samples.distance_sample),
        .last_sample     (samples.last_sample),
        .find_minimum    (find_minimum_reg),
        .res_load        (res_load),
        .res_data        (res_data)
    );

    erc_result_reg u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_load (res_load),
        .res_data (res_data),
        .can_take (can_take),
        .results  (results)
    );

endmodule

`default_nettype wire

>>> rtl/core/erc_run_tracker.sv
// per-sample extreme and run tracking, builds the result on the last sample
// depends on erc_pkg and extreme_run_center_select_macros.svh
`default_nettype none
`include "extreme_run_center_select_macros.svh"

module erc_run_tracker #(
    parameter int MAX_ITEMS = erc_pkg::MAX_ITEMS_DEF,
    parameter int DIST_BITS = erc_pkg::DIST_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         take,
    input  wire logic [erc_pkg::SAMPLE_W-1:0] distance_sample,
    input  wire logic                         last_sample,
    input  wire logic                         find_minimum,
    output      logic                         res_load,
    output      erc_pkg::result_t             res_data
);

    localparam int DW    = (DIST_BITS < erc_pkg::SAMPLE_W) ? DIST_BITS : erc_pkg::SAMPLE_W;
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CW    = (IDX_W > erc_pkg::CENTER_W) ? IDX_W : erc_pkg::CENTER_W;

    logic [CNT_W-1:0] count_reg, count_next, count_upd;
    logic [DW-1:0]    extreme_reg, extreme_next, extreme_upd;
    logic [IDX_W-1:0] run_start_reg, run_start_next, run_start_upd;
    logic [IDX_W-1:0] run_extra_reg, run_extra_next, run_extra_upd;
    logic             in_run_reg, in_run_next, in_run_upd;
    logic [IDX_W-1:0] best_start_reg, best_start_next, best_start_upd;
    logic [IDX_W-1:0] best_extra_reg, best_extra_next, best_extra_upd;
    logic             overflow_reg, overflow_next, overflow_upd;

    logic [DW-1:0]    sample;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] extra_inc;
    logic             better;
    logic             end_seq;
    logic [CW-1:0]    center_wide;
    logic [CNT_W-1:0] best_end;

    assign sample    = distance_sample[DW-1:0];
    assign idx       = count_reg[IDX_W-1:0];
    assign extra_inc = run_extra_reg + IDX_W'(1);
    assign better    = find_minimum ? (sample < extreme_reg) : (sample > extreme_reg);
    assign end_seq   = take && last_sample;

    always_comb
    begin
        count_upd      = count_reg;
        extreme_upd    = extreme_reg;
        run_start_upd  = run_start_reg;
        run_extra_upd  = run_extra_reg;
        in_run_upd     = in_run_reg;
        best_start_upd = best_start_reg;
        best_extra_upd = best_extra_reg;
        overflow_upd   = overflow_reg;
        if (take)
        begin
            if (count_reg < CNT_W'(MAX_ITEMS))
            begin
                count_upd = count_reg + CNT_W'(1);
                if (count_reg == '0 || better)
                begin
                    extreme_upd    = sample;
                    run_start_upd  = idx;
                    run_extra_upd  = '0;
                    in_run_upd     = 1'b1;
                    best_start_upd = idx;
                    best_extra_upd = '0;
                end
                else if (sample == extreme_reg)
                begin
                    if (in_run_reg)
                    begin
                        run_extra_upd = extra_inc;
                        // strictly longer only, so the earliest run keeps ties
                        if (extra_inc > best_extra_reg)
                        begin
                            best_start_upd = run_start_reg;
                            best_extra_upd = extra_inc;
                        end
                    end
                    else
                    begin
                        in_run_upd    = 1'b1;
                        run_start_upd = idx;
                        run_extra_upd = '0;
                    end
                end
                else
                begin
                    in_run_upd = 1'b0;
                end
            end
            else
            begin
                overflow_upd = 1'b1;
            end
        end
    end

    // sequence state clears once the last sample has been folded in
    always_comb
    begin
        if (end_seq)
        begin
            count_next      = '0;
            extreme_next    = '0;
            run_start_next  = '0;
            run_extra_next  = '0;
            in_run_next     = 1'b0;
            best_start_next = '0;
            best_extra_next = '0;
            overflow_next   = 1'b0;
        end
        else
        begin
            count_next      = count_upd;
            extreme_next    = extreme_upd;
            run_start_next  = run_start_upd;
            run_extra_next  = run_extra_upd;
            in_run_next     = in_run_upd;
            best_start_next = best_start_upd;
            best_extra_next = best_extra_upd;
            overflow_next   = overflow_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            extreme_reg    <= '0;
            run_start_reg  <= '0;
            run_extra_reg  <= '0;
            in_run_reg     <= 1'b0;
            best_start_reg <= '0;
            best_extra_reg <= '0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            extreme_reg    <= extreme_next;
            run_start_reg  <= run_start_next;
            run_extra_reg  <= run_extra_next;
            in_run_reg     <= in_run_next;
            best_start_reg <= best_start_next;
            best_extra_reg <= best_extra_next;
            overflow_reg   <= overflow_next;
        end
    end

    assign center_wide = CW'(best_start_upd) + CW'(best_extra_upd >> 1);

    assign res_load                  = end_seq;
    assign res_data.center_index     = center_wide[erc_pkg::CENTER_W-1:0];
    assign res_data.extreme_distance = erc_pkg::SAMPLE_W'(extreme_upd);
    assign res_data.overflow         = overflow_upd;

    assign best_end = CNT_W'(best_start_reg) + CNT_W'(best_extra_reg);

    `ERC_ASSERT_NEXT(a_clear_after_last, clk, rst_n, end_seq, count_reg == '0)
    `ERC_ASSERT_IMPL(a_best_in_range, clk, rst_n, count_reg != '0, best_end < count_reg)
    `ERC_ASSERT_IMPL(a_overflow_full, clk, rst_n, overflow_reg,
                     count_reg == CNT_W'(MAX_ITEMS))

endmodule

`default_nettype wire

>>> rtl/core/erc_result_reg.sv
// output register for results, decouples the result channel from the tracker
// depends on erc_pkg and erc_out_if
`default_nettype none

module erc_result_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_load,
    input  wire erc_pkg::result_t res_data,
    output      logic             can_take,
    erc_out_if.source             results
);

    logic             valid_reg, valid_next;
    erc_pkg::result_t data_reg;

    // room when empty or when the held transaction leaves this cycle
    assign can_take = !valid_reg || results.ready;

    always_comb
    begin
        if (res_load)
            valid_next = 1'b1;
        else if (results.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            data_reg <= res_data;
    end

    assign results.valid            = valid_reg;
    assign results.center_index     = data_reg.center_index;
    assign results.extreme_distance = data_reg.extreme_distance;
    assign results.overflow         = data_reg.overflow;

endmodule

`default_nettype wire
